[sv/bpeq_pkg.sv]
// Shared types and constants for the button press event qualifier.
// No dependencies; imported by the lane, merge and top modules.
`timescale 1ns / 1ps

package bpeq_pkg;

  // width of the map and button index in a result item
  localparam int unsigned MapW = 10;
  localparam int unsigned IdxOutW = 4;
  localparam int unsigned EdgeButtons = 10;

  typedef enum logic [1:0] {
    EvPress   = 2'd0,
    EvRelease = 2'd1,
    EvClick   = 2'd2,
    EvHold    = 2'd3
  } ev_kind_e;

  typedef enum logic {
    CmdEdge = 1'b0,
    CmdTick = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    RegDebounce = 3'd0,
    RegLongPress = 3'd1,
    RegRepeatEn = 3'd2,
    RegRepeatDelay = 3'd3,
    RegRepeatIntv = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [15:0] deb_win_ms;
    logic [15:0] long_hold_ms;
    logic        repeat_en;
    logic [15:0] rep_delay_ms;
    logic [15:0] repeat_intv_ms;
  } cfg_t;

  typedef struct packed {
    cmd_e        cmd;
    logic [9:0]  mask;
    logic [9:0]  levels;
    logic [31:0] now;
  } item_t;

  // what one lane found for the current item: up to two events
  typedef struct packed {
    logic        ev0;
    ev_kind_e    kind0;
    logic        ev1;
    ev_kind_e    kind1;
    logic [31:0] held;
    logic        pressed;
  } lane_res_t;

endpackage

[sv/button_press_event_qualifier_top.sv]
// Top level of the button press event qualifier: registers, control, lanes.
// Depends on bpeq_pkg, bpeq_lane and bpeq_merge.
`timescale 1ns / 1ps

// One lane per button evaluates an item; the merge stage then sends the
// events out one per cycle in button order while the output is not stalled,
// at most two per button for each item, and the next item is taken once the
// last event has been moved into the output register. Tick items ignore mask
// and levels; every event carries the debounced pressed map and the final one
// of an item is marked.
module button_press_event_qualifier_top #(
  parameter int unsigned NumButtons = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [9:0]  changed_mask_i,
  input  logic [9:0]  raw_levels_i,
  input  logic [31:0] now_ms_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  button_index_o,
  output logic [1:0]  event_kind_o,
  output logic [31:0] held_ms_o,
  output logic [31:0] stamp_ms_o,
  output logic [9:0]  pressed_map_o,
  output logic        last_of_run_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);
  import bpeq_pkg::*;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StEval = 3'b010,
    StWalk = 3'b100
  } state_e;

  state_e                state_q, state_d;
  cfg_t                  cfg_q;
  item_t                 item_q;
  lane_res_t             res [NumButtons];
  logic [NumButtons-1:0] old_map;
  logic                  busy, accept, eval;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign eval       = (state_q == StEval);

  // control
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (accept) state_d = StEval;
      StEval: state_d = StWalk;
      StWalk: if (!busy) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // input item register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.cmd    <= cmd_e'(command_i);
      item_q.mask   <= changed_mask_i;
      item_q.levels <= raw_levels_i;
      item_q.now    <= now_ms_i;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.deb_win_ms     <= 16'd20;
      cfg_q.long_hold_ms   <= 16'd1000;
      cfg_q.repeat_en      <= 1'b0;
      cfg_q.rep_delay_ms   <= 16'd500;
      cfg_q.repeat_intv_ms <= 16'd100;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegDebounce:    cfg_q.deb_win_ms     <= cfg_wdata_i;
        RegLongPress:   cfg_q.long_hold_ms   <= cfg_wdata_i;
        RegRepeatEn:    cfg_q.repeat_en      <= cfg_wdata_i[0];
        RegRepeatDelay: cfg_q.rep_delay_ms   <= cfg_wdata_i;
        RegRepeatIntv:  cfg_q.repeat_intv_ms <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // button lanes
  for (genvar g = 0; g < NumButtons; g++) begin : g_lane
    bpeq_lane #(.LaneIdx(g)) u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .eval_i    (eval),
      .item_i    (item_q),
      .cfg_i     (cfg_q),
      .res_o     (res[g]),
      .pressed_o (old_map[g])
    );
  end

  // merge stage
  bpeq_merge #(.NumButtons(NumButtons)) u_merge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (eval),
    .res_i          (res),
    .old_map_i      (old_map),
    .now_i          (item_q.now),
    .busy_o         (busy),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .button_index_o (button_index_o),
    .event_kind_o   (event_kind_o),
    .held_ms_o      (held_ms_o),
    .stamp_ms_o     (stamp_ms_o),
    .pressed_map_o  (pressed_map_o),
    .last_of_run_o  (last_of_run_o)
  );

  a_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  a_eval_once : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (eval ##1 !eval)) else $error("eval not a single cycle");
  a_idle_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> !busy) else $error("events pending while idle");

endmodule

[sv/bpeq_lane.sv]
// One button lane: debounce, press/release/click, hold and repeat decisions.
// Depends on bpeq_pkg.
`timescale 1ns / 1ps

module bpeq_lane #(
  parameter int unsigned LaneIdx = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              eval_i,
  input  bpeq_pkg::item_t   item_i,
  input  bpeq_pkg::cfg_t    cfg_i,
  output bpeq_pkg::lane_res_t res_o,
  output logic              pressed_o
);
  import bpeq_pkg::*;

  logic        pf_q, pf_d, hf_q, hf_d, rs_q, rs_d;
  logic [31:0] ps_q, ps_d, chg_q, chg_d, rst_q, rst_d;
  logic [31:0] mask_ext, lvl_ext, since_chg, dur, since_rep;
  logic [16:0] first_rep;
  logic        active, pr, hold_now, hf_new, due;

  assign mask_ext  = 32'(item_i.mask);
  assign lvl_ext   = 32'(item_i.levels);
  assign since_chg = item_i.now - chg_q;
  assign dur       = item_i.now - ps_q;
  assign since_rep = item_i.now - rst_q;
  assign first_rep = 17'(cfg_i.long_hold_ms) + 17'(cfg_i.rep_delay_ms);
  assign active    = (LaneIdx < EdgeButtons) && mask_ext[LaneIdx]
                     && (since_chg >= 32'(cfg_i.deb_win_ms));
  assign pr        = !lvl_ext[LaneIdx];
  assign hold_now  = !hf_q && (dur >= 32'(cfg_i.long_hold_ms));
  assign hf_new    = hf_q || hold_now;
  assign due       = rs_q ? (since_rep >= 32'(cfg_i.repeat_intv_ms))
                          : (dur >= 32'(first_rep));

  // event decisions and next state
  always_comb begin
    pf_d = pf_q; hf_d = hf_q; rs_d = rs_q;
    ps_d = ps_q; chg_d = chg_q; rst_d = rst_q;
    res_o.ev0   = 1'b0;
    res_o.kind0 = EvPress;
    res_o.ev1   = 1'b0;
    res_o.kind1 = EvPress;
    res_o.held  = dur;
    if (item_i.cmd == CmdEdge) begin
      res_o.kind1 = EvClick;
      if (active && (pr != pf_q)) begin
        pf_d  = pr;
        chg_d = item_i.now;
        res_o.ev0 = 1'b1;
        if (pr) begin
          ps_d = item_i.now;
          hf_d = 1'b0;
          rs_d = 1'b0;
          res_o.kind0 = EvPress;
          res_o.held  = '0;
        end else begin
          res_o.kind0 = EvRelease;
          res_o.ev1   = !hf_q && (dur < 32'(cfg_i.long_hold_ms));
        end
      end
    end else if (pf_q) begin
      res_o.kind0 = EvHold;
      res_o.ev0   = hold_now;
      hf_d        = hf_new;
      if (cfg_i.repeat_en && hf_new && due) begin
        res_o.ev1 = 1'b1;
        rs_d      = 1'b1;
        rst_d     = item_i.now;
      end
    end
    res_o.pressed = pf_d;
  end

  assign pressed_o = pf_q;

  // per-button state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pf_q <= 1'b0; hf_q <= 1'b0; rs_q <= 1'b0;
      ps_q <= '0; chg_q <= '0; rst_q <= '0;
    end else if (eval_i) begin
      pf_q <= pf_d; hf_q <= hf_d; rs_q <= rs_d;
      ps_q <= ps_d; chg_q <= chg_d; rst_q <= rst_d;
    end
  end

endmodule

[sv/bpeq_merge.sv]
// Merge stage: collects lane events and sends them out in button order.
// Depends on bpeq_pkg.
`timescale 1ns / 1ps

module bpeq_merge #(
  parameter int unsigned NumButtons = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  bpeq_pkg::lane_res_t res_i [NumButtons],
  input  logic [NumButtons-1:0] old_map_i,
  input  logic [31:0]         now_i,
  output logic                busy_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [3:0]          button_index_o,
  output logic [1:0]          event_kind_o,
  output logic [31:0]         held_ms_o,
  output logic [31:0]         stamp_ms_o,
  output logic [9:0]          pressed_map_o,
  output logic                last_of_run_o
);
  import bpeq_pkg::*;

  localparam int unsigned IdxW = (NumButtons > 1) ? $clog2(NumButtons) : 1;
  localparam int unsigned ExtW = (NumButtons > MapW) ? NumButtons : MapW;

  logic [NumButtons-1:0] p0_q, p0_d, p1_q, p1_d, new_q, old_q;
  ev_kind_e              k0_q [NumButtons];
  ev_kind_e              k1_q [NumButtons];
  logic [31:0]           held_q [NumButtons];
  logic [IdxW-1:0]       sel;
  logic [ExtW-1:0]       old_ext, new_ext, map_ext;
  logic                  emit, last, valid_q;
  logic [NumButtons-1:0] others;

  assign busy_o = |(p0_q | p1_q);
  assign emit   = busy_o && (!valid_q || out_ready_i);

  // lowest pending lane
  always_comb begin
    sel = '0;
    for (int j = NumButtons - 1; j >= 0; j--) begin
      if (p0_q[j] || p1_q[j]) sel = IdxW'(j);
    end
  end

  // pending bits after this emit
  always_comb begin
    p0_d = p0_q;
    p1_d = p1_q;
    if (emit) begin
      if (p0_q[sel]) p0_d[sel] = 1'b0;
      else p1_d[sel] = 1'b0;
    end
    others = p0_d | p1_d;
    last   = (others == '0);
  end

  // map after the emitted event: lanes up to sel show their new state
  assign old_ext = ExtW'(old_q);
  assign new_ext = ExtW'(new_q);
  always_comb begin
    for (int k = 0; k < ExtW; k++) begin
      map_ext[k] = (k <= int'(sel)) ? new_ext[k] : old_ext[k];
    end
  end

  // lane results and pending bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_q <= '0;
      p1_q <= '0;
    end else if (load_i) begin
      for (int j = 0; j < NumButtons; j++) begin
        p0_q[j] <= res_i[j].ev0;
        p1_q[j] <= res_i[j].ev1;
      end
    end else begin
      p0_q <= p0_d;
      p1_q <= p1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      old_q <= old_map_i;
      for (int j = 0; j < NumButtons; j++) begin
        new_q[j]  <= res_i[j].pressed;
        k0_q[j]   <= res_i[j].kind0;
        k1_q[j]   <= res_i[j].kind1;
        held_q[j] <= res_i[j].held;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (emit) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      button_index_o <= IdxOutW'(sel);
      event_kind_o   <= p0_q[sel] ? k0_q[sel] : k1_q[sel];
      held_ms_o      <= held_q[sel];
      stamp_ms_o     <= now_i;
      pressed_map_o  <= map_ext[MapW-1:0];
      last_of_run_o  <= last;
    end
  end

  assign out_valid_o = valid_q;

  a_load_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> !busy_o) else $error("lane results loaded while walk busy");
  a_last_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && last && !load_i) |=> !busy_o) else $error("events left after last");
  a_emit_pend : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (p0_q[sel] || p1_q[sel])) else $error("emit from idle lane");

endmodule
